FILE: rtl/smf_pkg.sv
// Shared constants, register indexes and helpers for the selective mean filter.
package smf_pkg;
    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_MAX_HEIGHT    = 1024;
    localparam int DEF_KERNEL_RADIUS = 2;

    localparam int DIM_W = 11;
    localparam int THR_W = 10;
    localparam int PIX_W = 24;
    localparam int CFG_W = 11;

    typedef enum logic [1:0] {
        REG_WIDTH     = 2'd0,
        REG_HEIGHT    = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_UNUSED    = 2'd3
    } cfg_reg_t;

    localparam logic [DIM_W-1:0] RST_WIDTH     = 11'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT    = 11'd480;
    localparam logic [THR_W-1:0] RST_THRESHOLD = 10'd20;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction
endpackage

FILE: rtl/smf_ram.sv
// Generic single-port RAM with registered read.
module smf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4101
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/selective_mean_filter_5x5_unit.sv
// Top level of the selective mean (sigma) filter over a square RGB window.
//
// Pixels enter on the s_ channel in raster order; s_tuser = 1 marks a flush
// tick that carries no pixel. A result leaves on the m_ channel for every item,
// bar a pixel-phase flush, once the stream is KERNEL_RADIUS*width + KERNEL_RADIUS
// items ahead of the window center; m_tlast flags the frame's final pixel. After
// a frame the host sends that many flush items to drain the outputs.
// Configuration: cfg_wr_en with cfg_index 0 = width, 1 = height,
// 2 = threshold. Writing width or height restarts the frame.
// Pacing: one item at a time; s_tready is high only in the idle state. An item
// that produces no result ends after evaluation; one that produces a result is
// paced by the single pixel-store port (request and accumulate states per tap)
// and by the bit-serial divider that follows it.
// Reset clears the stream position and output valid; the pixel store is not
// cleared. A stalled receiver holds the finished result in the output
// register; the next item is accepted meanwhile, and its result waits until
// the register frees.
module selective_mean_filter_5x5_unit #(
    parameter int MAX_WIDTH     = smf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = smf_pkg::DEF_MAX_HEIGHT,
    parameter int KERNEL_RADIUS = smf_pkg::DEF_KERNEL_RADIUS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // in_blue, in_green, in_red
    input  logic                       s_tuser,   // action
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // out_blue, out_green, out_red
    output logic                       m_tlast,   // frame_last
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [smf_pkg::CFG_W-1:0]  cfg_data
);
    import smf_pkg::*;

    localparam int R      = KERNEL_RADIUS;
    localparam int MAXW   = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam int MAXH   = (MAX_HEIGHT > 2047) ? 2047 : MAX_HEIGHT;
    localparam int DEPTH  = 2 * R * MAX_WIDTH + 2 * R + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW     = $clog2(MAXW * MAXH + R * MAXW + R + 2);
    localparam int TAPS   = (2 * R + 1) * (2 * R + 1);
    localparam int SW     = $clog2(TAPS * 255 + 1);
    localparam int CW     = $clog2(TAPS + 1);
    localparam int SCW    = $clog2(SW + 1);
    localparam logic [DIM_W-1:0] MAXW_L = DIM_W'(MAXW);
    localparam logic [DIM_W-1:0] MAXH_L = DIM_W'(MAXH);
    localparam logic signed [3:0] RP = 4'(R);
    localparam logic signed [3:0] RN = -4'(R);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_EVAL  = 8'b0000_0010,
        ST_CREQ  = 8'b0000_0100,
        ST_CWAIT = 8'b0000_1000,
        ST_NREQ  = 8'b0001_0000,
        ST_NACC  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t            state_reg;
    logic [DIM_W-1:0]  w_reg, h_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [PW-1:0]     npix_reg, lag_reg, pos_reg;
    logic              act_reg;
    logic [PIX_W-1:0]  px_reg, ctr_reg;
    logic [AW-1:0]     paddr_reg, qaddr_reg, nb_addr_reg;
    logic [DIM_W-1:0]  qrow_reg, qcol_reg;
    logic signed [3:0] dr_reg, dc_reg;
    logic [SW-1:0]     sb_reg, sg_reg, sr_reg;
    logic [CW-1:0]     cnt_reg, rb_reg, rg_reg, rr_reg;
    logic [SCW-1:0]    step_reg;
    logic              m_valid_reg, m_last_reg;
    logic [23:0]       m_data_reg;

    logic [DIM_W-1:0]  w_c, h_c;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [PIX_W-1:0]  ram_rdata;

    always_comb begin
        w_c = (w_reg == '0) ? DIM_W'(1) : ((w_reg > MAXW_L) ? MAXW_L : w_reg);
        h_c = (h_reg == '0) ? DIM_W'(1) : ((h_reg > MAXH_L) ? MAXH_L : h_reg);
    end

    function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a,
                                              input logic signed [AW+2:0] d);
        logic signed [AW+2:0] t;
        t = $signed({3'b0, a}) + d;
        if (t < 0) begin
            t = t + (AW+3)'(DEPTH);
        end else if (t >= (AW+3)'(DEPTH)) begin
            t = t - (AW+3)'(DEPTH);
        end
        return t[AW-1:0];
    endfunction

    // Window tap checks
    logic signed [DIM_W+2:0] tap_r, tap_c;
    logic                    tap_in, tap_ok;
    logic [9:0]              tap_diff;
    always_comb begin
        tap_r    = $signed({3'b0, qrow_reg}) + (DIM_W+3)'(dr_reg);
        tap_c    = $signed({3'b0, qcol_reg}) + (DIM_W+3)'(dc_reg);
        tap_in   = (tap_r >= 0) && (tap_c >= 0) &&
                   (tap_r < $signed({3'b0, h_c})) && (tap_c < $signed({3'b0, w_c}));
        tap_diff = 10'(abs_diff(ram_rdata[7:0], ctr_reg[7:0])) +
                   10'(abs_diff(ram_rdata[15:8], ctr_reg[15:8])) +
                   10'(abs_diff(ram_rdata[23:16], ctr_reg[23:16]));
        tap_ok   = tap_in && (tap_diff <= thr_reg);
    end

    // Restoring division steps, one quotient bit per cycle for each channel
    logic [CW:0] tb, tg, tr;
    logic        gb, gg, gr;
    always_comb begin
        tb = {rb_reg, sb_reg[SW-1]};
        tg = {rg_reg, sg_reg[SW-1]};
        tr = {rr_reg, sr_reg[SW-1]};
        gb = tb >= {1'b0, cnt_reg};
        gg = tg >= {1'b0, cnt_reg};
        gr = tr >= {1'b0, cnt_reg};
    end

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = nb_addr_reg;
        unique case (state_reg)
            ST_EVAL: begin
                ram_we   = (pos_reg < npix_reg) && !act_reg;
                ram_addr = paddr_reg;
            end
            ST_CREQ: ram_addr = qaddr_reg;
            default: ram_addr = nb_addr_reg;
        endcase
    end

    smf_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (px_reg),
        .rdata (ram_rdata)
    );

    logic q_last;
    assign q_last = (qrow_reg == h_c - DIM_W'(1)) && (qcol_reg == w_c - DIM_W'(1));

    always_ff @(posedge aclk) begin
        npix_reg <= PW'(w_c * h_c);
        lag_reg  <= PW'(R * w_c + R);
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            w_reg       <= RST_WIDTH;
            h_reg       <= RST_HEIGHT;
            thr_reg     <= RST_THRESHOLD;
            pos_reg     <= '0;
            paddr_reg   <= '0;
            qaddr_reg   <= '0;
            nb_addr_reg <= '0;
            qrow_reg    <= '0;
            qcol_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        act_reg   <= s_tuser;
                        px_reg    <= s_tdata;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (pos_reg < npix_reg && act_reg) begin
                        state_reg <= ST_IDLE;   // flush during pixel phase
                    end else begin
                        if (pos_reg < npix_reg) begin
                            paddr_reg <= add_mod(paddr_reg, (AW+3)'(1));
                        end
                        pos_reg <= pos_reg + PW'(1);
                        if (pos_reg < lag_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            nb_addr_reg <= add_mod(qaddr_reg, -$signed((AW+3)'(lag_reg)));
                            dr_reg      <= RN;
                            dc_reg      <= RN;
                            state_reg   <= ST_CREQ;
                        end
                    end
                end
                ST_CREQ: state_reg <= ST_CWAIT;
                ST_CWAIT: begin
                    ctr_reg   <= ram_rdata;
                    sb_reg    <= '0;
                    sg_reg    <= '0;
                    sr_reg    <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_NREQ;
                end
                ST_NREQ: state_reg <= ST_NACC;
                ST_NACC: begin
                    if (tap_ok) begin
                        sb_reg  <= sb_reg + SW'(ram_rdata[7:0]);
                        sg_reg  <= sg_reg + SW'(ram_rdata[15:8]);
                        sr_reg  <= sr_reg + SW'(ram_rdata[23:16]);
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (dc_reg == RP) begin
                        dc_reg      <= RN;
                        dr_reg      <= dr_reg + 4'sd1;
                        nb_addr_reg <= add_mod(nb_addr_reg,
                                       $signed((AW+3)'(w_c)) - (AW+3)'(2 * R));
                    end else begin
                        dc_reg      <= dc_reg + 4'sd1;
                        nb_addr_reg <= add_mod(nb_addr_reg, (AW+3)'(1));
                    end
                    if (dc_reg == RP && dr_reg == RP) begin
                        rb_reg    <= '0;
                        rg_reg    <= '0;
                        rr_reg    <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        state_reg <= ST_NREQ;
                    end
                end
                ST_DIV: begin
                    rb_reg   <= gb ? CW'(tb - {1'b0, cnt_reg}) : tb[CW-1:0];
                    rg_reg   <= gg ? CW'(tg - {1'b0, cnt_reg}) : tg[CW-1:0];
                    rr_reg   <= gr ? CW'(tr - {1'b0, cnt_reg}) : tr[CW-1:0];
                    sb_reg   <= {sb_reg[SW-2:0], gb};
                    sg_reg   <= {sg_reg[SW-2:0], gg};
                    sr_reg   <= {sr_reg[SW-2:0], gr};
                    step_reg <= step_reg + SCW'(1);
                    if (step_reg == SCW'(SW - 1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {sr_reg[7:0], sg_reg[7:0], sb_reg[7:0]};
                        m_last_reg  <= q_last;
                        state_reg   <= ST_IDLE;
                        if (q_last) begin
                            pos_reg   <= '0;
                            paddr_reg <= '0;
                            qaddr_reg <= '0;
                            qrow_reg  <= '0;
                            qcol_reg  <= '0;
                        end else begin
                            qaddr_reg <= add_mod(qaddr_reg, (AW+3)'(1));
                            if (qcol_reg == w_c - DIM_W'(1)) begin
                                qcol_reg <= '0;
                                qrow_reg <= qrow_reg + DIM_W'(1);
                            end else begin
                                qcol_reg <= qcol_reg + DIM_W'(1);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_WIDTH, REG_HEIGHT: begin
                        if (cfg_reg_t'(cfg_index) == REG_WIDTH) begin
                            w_reg <= cfg_data;
                        end else begin
                            h_reg <= cfg_data;
                        end
                        pos_reg   <= '0;
                        paddr_reg <= '0;
                        qaddr_reg <= '0;
                        qrow_reg  <= '0;
                        qcol_reg  <= '0;
                    end
                    REG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    REG_UNUSED: ;
                    default: ;
                endcase
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !cfg_wr_en |=> state_reg == ST_EVAL)
        else $error("accepted item did not move to evaluation");
    a_center_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> cnt_reg != '0)
        else $error("divisor is zero");
    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        paddr_reg < AW'(DEPTH) && qaddr_reg < AW'(DEPTH) && nb_addr_reg < AW'(DEPTH))
        else $error("store address out of range");
endmodule

FILE: test/tb.sv
// Self-checking testbench for the selective mean filter unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import smf_pkg::*;

    localparam int MAXW      = DEF_MAX_WIDTH;
    localparam int MAXH      = DEF_MAX_HEIGHT;
    localparam int RAD       = DEF_KERNEL_RADIUS;
    localparam int DEPTH     = 2 * RAD * MAXW + 2 * RAD + 1;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_ITEMS   = 1150;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pix_out_t;

    typedef struct {
        bit          flush;
        logic [23:0] pix;
        bit          typed;
        pix_out_t    want;
    } row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    selective_mean_filter_5x5_unit dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [23:0] pix_mem [DEPTH];
    int unsigned cur_w = RST_WIDTH, cur_h = RST_HEIGHT, cur_thr = RST_THRESHOLD;
    int unsigned pos = 0;

    pix_out_t    pending[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          typed_now = 0;
    pix_out_t    typed_val;
    bit          hold_go = 0;
    int          items_sent = 0;

    function automatic int unsigned clampd(int unsigned v, int unsigned m);
        return (v < 1) ? 1 : ((v > m) ? m : v);
    endfunction

    function automatic int unsigned adiff(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Returns 1 when the item produces a filtered pixel.
    function automatic bit filter_step(bit flush, logic [23:0] px, output pix_out_t res);
        int unsigned w, h, npix, lag, q, cnt, sb, sg, sr;
        int r0, c0, r, c;
        logic [23:0] ctr, nb;
        w = clampd(cur_w, MAXW);
        h = clampd(cur_h, MAXH);
        npix = w * h;
        lag = RAD * w + RAD;
        res = '0;
        if (pos < npix) begin
            if (flush) return 0;
            pix_mem[pos % DEPTH] = px;
        end
        pos++;
        if (pos - 1 < lag) return 0;
        q = pos - 1 - lag;
        r0 = q / w;
        c0 = q % w;
        ctr = pix_mem[q % DEPTH];
        cnt = 0; sb = 0; sg = 0; sr = 0;
        for (int dr = -RAD; dr <= RAD; dr++) begin
            for (int dc = -RAD; dc <= RAD; dc++) begin
                r = r0 + dr;
                c = c0 + dc;
                if (r < 0 || c < 0 || r >= int'(h) || c >= int'(w)) continue;
                nb = pix_mem[(r * w + c) % DEPTH];
                if (adiff(nb[7:0], ctr[7:0]) + adiff(nb[15:8], ctr[15:8])
                    + adiff(nb[23:16], ctr[23:16]) <= cur_thr) begin
                    sb += nb[7:0]; sg += nb[15:8]; sr += nb[23:16]; cnt++;
                end
            end
        end
        if (cnt == 0) cnt = 1;
        if (q + 1 >= npix) begin
            res.last = 1;
            pos = 0;
        end
        res.blue = 8'(sb / cnt);
        res.green = 8'(sg / cnt);
        res.red = 8'(sr / cnt);
        return 1;
    endfunction

    // monitor: predict on input handshake, compare on output handshake
    always @(posedge aclk) begin
        pix_out_t p, got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (filter_step(s_tuser, s_tdata, p)) begin
                    if (typed_now) p = typed_val;
                    pending = {pending, p};
                end
            end
            if (m_tvalid && m_tready) begin
                got = '{red: m_tdata[23:16], green: m_tdata[15:8],
                        blue: m_tdata[7:0], last: m_tlast};
                if (pending.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item %h", $time, got);
                end else begin
                    p = pending.pop_front();
                    if (got !== p) begin
                        errors++;
                        $display("%0t: mismatch expected b=%h g=%h r=%h last=%b, got b=%h g=%h r=%h last=%b",
                                 $time, p.blue, p.green, p.red, p.last,
                                 got.blue, got.green, got.red, got.last);
                    end
                end
            end
        end
    end

    // watchdog on progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL selective_mean_filter_5x5_unit");
            $finish;
        end
    end

    // receiver: mixed stall patterns plus one long hold-off
    initial begin
        int mode, n;
        bit held;
        held = 0;
        forever begin
            if (hold_go && !held) begin
                held = 1;
                @(negedge aclk) m_tready <= 0;
                repeat (600) @(negedge aclk);
            end
            mode = $urandom_range(0, 9);
            n = $urandom_range(1, 40);
            repeat (n) begin
                @(negedge aclk);
                if (mode < 4) m_tready <= 1;
                else if (mode < 9) m_tready <= ($urandom_range(0, 3) != 0);
                else m_tready <= 0;
            end
        end
    end

    task automatic cfg_write(cfg_reg_t idx, int unsigned val);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge aclk);
        case (idx)
            REG_WIDTH: begin cur_w = val & 11'h7FF; pos = 0; end
            REG_HEIGHT: begin cur_h = val & 11'h7FF; pos = 0; end
            REG_THRESHOLD: cur_thr = val & 10'h3FF;
            default: ;
        endcase
        @(negedge aclk) cfg_wr_en <= 0;
    endtask

    task automatic drain;
        wait (pending.size() == 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic send(bit flush, logic [23:0] px, bit typed, pix_out_t want);
        if ($urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                              : $urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= flush;
        s_tdata <= px;
        typed_now <= typed;
        typed_val <= want;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic run_frame(int unsigned wreg, int unsigned hreg, bit rich);
        int unsigned w, h, lag;
        logic [23:0] base, px;
        pix_out_t none;
        none = '0;
        drain();
        cfg_write(REG_WIDTH, wreg);
        cfg_write(REG_HEIGHT, hreg);
        w = clampd(wreg, MAXW);
        h = clampd(hreg, MAXH);
        lag = RAD * w + RAD;
        base = 24'($urandom);
        for (int i = 0; i < w * h; i++) begin
            if (rich && $urandom_range(0, 9) == 0) send(1, 24'($urandom), 0, none);
            if ($urandom_range(0, 3) == 0) px = 24'($urandom);
            else px = {base[23:16] + 8'($urandom_range(0, 15)),
                       base[15:8] + 8'($urandom_range(0, 15)),
                       base[7:0] + 8'($urandom_range(0, 15))};
            send(0, px, 0, none);
        end
        for (int i = 0; i < lag; i++)
            send(!(rich && $urandom_range(0, 7) == 0), 24'($urandom), 0, none);
        s_tvalid <= 0;
    endtask

    row_t rows[$];

    initial begin
        pix_out_t none;
        int unsigned thr;
        none = '0;
        foreach (pix_mem[i]) pix_mem[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;

        // single-pixel frames: result equals the pixel
        cfg_write(REG_WIDTH, 1);
        cfg_write(REG_HEIGHT, 1);
        cfg_write(REG_UNUSED, 5);
        rows = '{
            '{1, 24'h123456, 0, none},          // flush in pixel phase: ignored
            '{0, 24'hFFFFFF, 0, none},
            '{1, 24'h0, 0, none}, '{1, 24'h0, 0, none}, '{1, 24'h0, 0, none},
            '{1, 24'h0, 1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
            '{0, 24'h000000, 0, none},
            '{0, 24'hABCDEF, 0, none},          // pixel in flush phase: dropped
            '{1, 24'h0, 0, none}, '{0, 24'h55AA55, 0, none},
            '{1, 24'h0, 1, '{8'h00, 8'h00, 8'h00, 1'b1}},
            '{0, 24'hFF0080, 0, none},
            '{1, 24'h0, 0, none}, '{1, 24'h0, 0, none}, '{1, 24'h0, 0, none},
            '{1, 24'h0, 1, '{8'hFF, 8'h00, 8'h80, 1'b1}}
        };
        foreach (rows[i]) send(rows[i].flush, rows[i].pix, rows[i].typed, rows[i].want);
        s_tvalid <= 0;
        typed_now <= 0;

        drain();
        cfg_write(REG_THRESHOLD, 0);
        run_frame(0, 0, 0);
        run_frame(5, 3, 1);
        drain();
        cfg_write(REG_THRESHOLD, 1023);
        run_frame(4, 4, 1);
        drain();
        cfg_write(REG_THRESHOLD, 765);
        hold_go = 1;
        run_frame(1, 2047, 0);

        while (items_sent < N_ITEMS) begin
            drain();
            case ($urandom_range(0, 4))
                0: thr = 0;
                1: thr = $urandom_range(766, 1023);
                2: thr = $urandom_range(0, 1023);
                default: thr = $urandom_range(0, 60);
            endcase
            cfg_write(REG_THRESHOLD, thr);
            if ($urandom_range(0, 9) == 0)
                run_frame($urandom_range(1, 20), $urandom_range(1, 2), 1);
            else
                run_frame($urandom_range(0, 7), $urandom_range(0, 6), 1);
        end

        wait (pending.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending.size() == 0)
            $display("PASS selective_mean_filter_5x5_unit");
        else
            $display("FAIL selective_mean_filter_5x5_unit");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/smf_pkg.sv
rtl/smf_ram.sv
rtl/selective_mean_filter_5x5_unit.sv
test/tb.sv
